// ===== sv/sac_pkg.sv =====
// ----------------------------------------------------------------------------
// sac_pkg
// Shared types, constants and helpers for the size-class slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sac_pkg;

  // Pool geometry
  localparam int SLOTS_PER_CLASS = 64;
  localparam int NUM_CLASSES     = 4;
  localparam int MAX_REQ_BYTES   = 512;

  // Field widths fixed by the interface
  localparam int SIZE_W = 16;
  localparam int SLOT_W = 6;
  localparam int CLS_W  = 2;
  localparam int ST_W   = 3;

  // Derived widths
  localparam int CNT_W  = $clog2(SLOTS_PER_CLASS + 1);
  localparam int POS_W  = $clog2(SLOTS_PER_CLASS);
  localparam int ADDR_W = CLS_W + POS_W;
  localparam int NCLS_SLOTS = 1 << CLS_W;

  // Result codes
  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_OVERSIZE  = 3'd2,
    ST_REJECTED  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load;   // capture input word
    logic exec;   // decode, update count, issue stack access
    logic pop;    // latch popped slot into result
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic need_pop;  // allocate succeeds, stack read in flight
  } sts_t;

  // Size to class: <=64, <=128, <=256, else class 3
  function automatic logic [CLS_W-1:0] class_of(input logic [SIZE_W-1:0] size);
    logic [CLS_W-1:0] c;
    if (size <= 16'd64)       c = 2'd0;
    else if (size <= 16'd128) c = 2'd1;
    else if (size <= 16'd256) c = 2'd2;
    else                      c = 2'd3;
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sac_datapath.sv =====
// ----------------------------------------------------------------------------
// sac_datapath
// Request registers, per-class free counts, the free-slot stack memory and
// the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire sac_pkg::cmd_t              cmd,
  output sac_pkg::sts_t                   sts,
  input  wire logic                       in_kind,
  input  wire logic [sac_pkg::SIZE_W-1:0] in_req_size,
  input  wire logic                       in_has_handle,
  input  wire logic [sac_pkg::SLOT_W-1:0] in_slot_in,
  output logic [sac_pkg::ST_W-1:0]        out_status,
  output logic [sac_pkg::CLS_W-1:0]       out_size_class,
  output logic [sac_pkg::SLOT_W-1:0]      out_slot_out
);

  localparam int SizeW  = sac_pkg::SIZE_W;
  localparam int SlotW  = sac_pkg::SLOT_W;
  localparam int ClsW   = sac_pkg::CLS_W;
  localparam int CntW   = sac_pkg::CNT_W;
  localparam int PosW   = sac_pkg::POS_W;
  localparam int AddrW  = sac_pkg::ADDR_W;
  localparam int NSlots = sac_pkg::NCLS_SLOTS;
  localparam logic [CntW-1:0]  CntFull = CntW'(sac_pkg::SLOTS_PER_CLASS);
  localparam logic [SizeW-1:0] SizeMax = SizeW'(sac_pkg::MAX_REQ_BYTES);

  // Captured request word
  logic             kind_r;
  logic [SizeW-1:0] size_r;
  logic             has_r;
  logic [SlotW-1:0] slot_in_r;

  // Per-class stack depth and low-water mark. Stack positions at or above
  // the mark have been written by a push; those below still hold reset data.
  logic [CntW-1:0] cnt_r [NSlots];
  logic [CntW-1:0] low_r [NSlots];

  // Stack memory, one row per class
  logic [SlotW-1:0] mem [1 << AddrW];
  logic [SlotW-1:0] rd_r;

  // Pop bookkeeping and result registers
  logic [PosW-1:0]  pop_pos_r;
  logic             pop_hit_r;
  sac_pkg::status_t st_r;
  logic [ClsW-1:0]  cls_r;
  logic [SlotW-1:0] slot_r;

  // Decode
  logic             rej, over, alloc_ok, free_ok;
  logic [ClsW-1:0]  cls;
  logic [CntW-1:0]  cur_cnt, cnt_dec;
  logic [PosW-1:0]  pos_rd, pos_wr;
  sac_pkg::status_t res_st;

  always_comb begin
    cls      = sac_pkg::class_of(size_r);
    rej      = (kind_r && !has_r) || (size_r == '0);
    over     = (size_r > SizeMax) || (4'(cls) >= 4'(sac_pkg::NUM_CLASSES));
    cur_cnt  = cnt_r[cls];
    cnt_dec  = cur_cnt - 1'b1;
    pos_rd   = PosW'(cnt_dec);
    pos_wr   = PosW'(cur_cnt);
    alloc_ok = !rej && !over && !kind_r && (cur_cnt != '0) && (cur_cnt <= CntFull);
    free_ok  = !rej && !over && kind_r && (cur_cnt < CntFull);
    if (rej)                   res_st = sac_pkg::ST_REJECTED;
    else if (over)             res_st = sac_pkg::ST_OVERSIZE;
    else if (alloc_ok || free_ok) res_st = sac_pkg::ST_DONE;
    else if (kind_r)           res_st = sac_pkg::ST_FULL;
    else                       res_st = sac_pkg::ST_EXHAUSTED;
  end

  assign sts.need_pop = alloc_ok;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      size_r    <= in_req_size;
      has_r     <= in_has_handle;
      slot_in_r <= in_slot_in;
    end
  end

  // Counts and low-water marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NSlots; c++) begin
        cnt_r[c] <= CntFull;
        low_r[c] <= CntFull;
      end
    end else if (cmd.exec) begin
      if (alloc_ok) begin
        cnt_r[cls] <= cnt_dec;
        if (cnt_dec < low_r[cls]) low_r[cls] <= cnt_dec;
      end else if (free_ok) begin
        cnt_r[cls] <= cur_cnt + 1'b1;
      end
    end
  end

  // Stack memory: push writes, pop reads (registered)
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (free_ok) mem[{cls, pos_wr}] <= slot_in_r;
      rd_r <= mem[{cls, pos_rd}];
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_r      <= res_st;
      cls_r     <= (rej || over) ? '0 : cls;
      slot_r    <= '0;
      pop_pos_r <= pos_rd;
      pop_hit_r <= (cnt_dec >= low_r[cls]);
    end else if (cmd.pop) begin
      // never-written positions still hold their own index
      slot_r <= pop_hit_r ? rd_r : SlotW'(pop_pos_r);
    end
  end

  assign out_status     = st_r;
  assign out_size_class = cls_r;
  assign out_slot_out   = slot_r;

  // Checks (the request word is only defined while it executes)
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (cur_cnt <= CntFull))
    else $error("class count above pool size");

  a_low_mark: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (low_r[cls] <= cur_cnt))
    else $error("low-water mark above stack depth");

endmodule

`default_nettype wire

// ===== sv/sac_ctrl.sv =====
// ----------------------------------------------------------------------------
// sac_ctrl
// Sequencer for the allocator: capture, execute, optional pop, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module sac_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output sac_pkg::cmd_t      cmd,
  input  wire sac_pkg::sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  // Handshake and commands
  always_comb begin
    in_stall  = (state_r == S_EXEC) || (state_r == S_POP) ||
                ((state_r == S_DONE) && out_stall);
    out_valid = (state_r == S_DONE);
    cmd.load  = in_valid && !in_stall;
    cmd.exec  = (state_r == S_EXEC);
    cmd.pop   = (state_r == S_POP);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: state_nxt = sts.need_pop ? S_POP : S_DONE;
      S_POP:  state_nxt = S_DONE;
      S_DONE: begin
        if (!out_stall) state_nxt = in_valid ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // Checks
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_EXEC))
    else $error("accepted word not executed");

  a_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_EXEC) && !sts.need_pop) |=> (state_r == S_DONE))
    else $error("result not presented after execute");

  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> out_valid)
    else $error("popped slot not presented");

endmodule

`default_nettype wire

// ===== sv/size_class_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// size_class_slot_allocator
// Four-class fixed-slot allocator with a LIFO free stack per class.
// ----------------------------------------------------------------------------
// One request is in flight at a time. An accepted request enters the execute
// state, in which the class count updates and the stack memory is written or
// read, and its result word is presented in the following cycle; an allocate
// that pops a slot also passes through the pop state, as the free stacks sit
// in one 256 x 6 memory with a registered read port. The next request is
// accepted in the cycle the result is taken. No clearing pass follows reset:
// a per-class low-water mark tells pushed stack entries from ones still at
// their reset value.
`default_nettype none

module size_class_slot_allocator (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_kind,
  input  wire logic [sac_pkg::SIZE_W-1:0] in_req_size,
  input  wire logic                       in_has_handle,
  input  wire logic [sac_pkg::SLOT_W-1:0] in_slot_in,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [sac_pkg::ST_W-1:0]        out_status,
  output logic [sac_pkg::CLS_W-1:0]       out_size_class,
  output logic [sac_pkg::SLOT_W-1:0]      out_slot_out
);

  sac_pkg::cmd_t cmd;
  sac_pkg::sts_t sts;

  // Sequencer
  sac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Stacks, counts and result word
  sac_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_kind        (in_kind),
    .in_req_size    (in_req_size),
    .in_has_handle  (in_has_handle),
    .in_slot_in     (in_slot_in),
    .out_status     (out_status),
    .out_size_class (out_size_class),
    .out_slot_out   (out_slot_out)
  );

endmodule

`default_nettype wire
